/* rtl/priority_bitmap_ready_queue_defines.svh */
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue_defines.svh
// assertion macros used by the ready queue controller
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BITMAP_READY_QUEUE_DEFINES_SVH
`define PRIORITY_BITMAP_READY_QUEUE_DEFINES_SVH

// same-cycle implication
`define PBRQ_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pbrq: same-cycle check failed");

// next-cycle implication
`define PBRQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pbrq: next-cycle check failed");

`endif

/* rtl/pbrq_pkg.sv */
// ----------------------------------------------------------------------------
// pbrq_pkg
// types, constants and helpers of the priority bitmap ready queue
// ----------------------------------------------------------------------------
package pbrq_pkg;

   // field widths
   localparam int CMD_W       = 2;
   localparam int THREAD_ID_W = 6;
   localparam int PRIO_W      = 8;
   localparam int STATUS_W    = 2;

   // default sizes
   localparam int DEF_NUM_PRIOS   = 256;
   localparam int DEF_NUM_THREADS = 64;

   // second bitmap level: one word of priorities per group
   localparam int PRIOS_PER_GROUP = 32;
   localparam int GROUP_SHIFT     = 5;

   // command decode
   localparam logic [CMD_W-1:0] CMD_ENQ_HEAD   = 2'd1;
   localparam int               CMD_CHOOSE_BIT = 1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_CHOSE    = 2'd2,
      STATUS_KEPT     = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       enq_first;
      logic       enq_link;
      logic       find_group;
      logic       find_prio;
      logic       pop;
      logic       advance;
      logic       rsp_en;
      status_type rsp_code;
   } ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic tid_ready;
      logic prio_nonempty;
      logic group_any;
      logic keep_current;
      logic head_is_tail;
   } stat_type;

   // index of the highest set bit of one bitmap word
   function automatic logic [GROUP_SHIFT-1:0] top_bit32(
      input logic [PRIOS_PER_GROUP-1:0] v
   );
      logic [GROUP_SHIFT-1:0] n;
      n = '0;
      for (int i = 0; i < PRIOS_PER_GROUP; i++) begin
         if (v[i]) n = GROUP_SHIFT'(i);
      end
      return n;
   endfunction

endpackage

/* rtl/priority_bitmap_ready_queue.sv */
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue
// per-cpu ready queue: per-priority fifo lists with a two-level bitmap
// ----------------------------------------------------------------------------
// enqueue: lookup state, then a link state when the priority already holds
//   threads; the next start is taken when the result shows
// choose: group search, priority search, keep decision, pop, head advance;
//   an empty bitmap, a kept thread or a last entry popped ends it early;
//   steps follow dependent registered reads of head/tail, then link memory
// reset clears ready flags and bitmap at once; the link memories need no sweep

module priority_bitmap_ready_queue #(
   parameter int NUM_PRIOS   = pbrq_pkg::DEF_NUM_PRIOS,
   parameter int NUM_THREADS = pbrq_pkg::DEF_NUM_THREADS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [pbrq_pkg::CMD_W-1:0]       req_command,
   input  logic [pbrq_pkg::THREAD_ID_W-1:0] req_thread_id,
   input  logic [pbrq_pkg::PRIO_W-1:0]      req_prio,
   input  logic [pbrq_pkg::THREAD_ID_W-1:0] req_current_id,
   input  logic                            req_current_runnable,
   input  logic [pbrq_pkg::PRIO_W-1:0]      req_current_prio,
   input  logic                            req_current_budget_left,
   output logic                            rsp_valid,
   output logic [pbrq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pbrq_pkg::THREAD_ID_W-1:0] rsp_chosen_id,
   output logic [pbrq_pkg::PRIO_W-1:0]      rsp_chosen_prio
);

   import pbrq_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   // sequencer
   pbrq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .stat    (stat),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   // queue storage and result register
   pbrq_datapath #(
      .NUM_PRIOS   (NUM_PRIOS),
      .NUM_THREADS (NUM_THREADS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .ctrl                    (ctrl),
      .stat                    (stat),
      .req_command             (req_command),
      .req_thread_id           (req_thread_id),
      .req_prio                (req_prio),
      .req_current_id          (req_current_id),
      .req_current_runnable    (req_current_runnable),
      .req_current_prio        (req_current_prio),
      .req_current_budget_left (req_current_budget_left),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_chosen_id           (rsp_chosen_id),
      .rsp_chosen_prio         (rsp_chosen_prio)
   );

endmodule

/* rtl/pbrq_ram.sv */
// ----------------------------------------------------------------------------
// pbrq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pbrq_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pbrq_ctrl.sv */
// ----------------------------------------------------------------------------
// pbrq_ctrl
// command sequencer of the ready queue: enqueue and choose steps
// ----------------------------------------------------------------------------
`include "priority_bitmap_ready_queue_defines.svh"

module pbrq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pbrq_pkg::CMD_W-1:0] command,
   input  pbrq_pkg::stat_type        stat,
   output pbrq_pkg::ctrl_type        ctrl,
   output logic                      busy
);

   import pbrq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_LINK,
      ST_GROUP,
      ST_PRIO,
      ST_DECIDE,
      ST_POP,
      ST_ADVANCE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.rsp_code = STATUS_ENQUEUED;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = command[CMD_CHOOSE_BIT] ? ST_GROUP : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            priority if (stat.tid_ready) begin
               ctrl.rsp_en   = 1'b1;
               ctrl.rsp_code = STATUS_REJECTED;
               state_in      = ST_IDLE;
            end else if (!stat.prio_nonempty) begin
               ctrl.enq_first = 1'b1;
               ctrl.rsp_en    = 1'b1;
               ctrl.rsp_code  = STATUS_ENQUEUED;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            ctrl.enq_link = 1'b1;
            ctrl.rsp_en   = 1'b1;
            ctrl.rsp_code = STATUS_ENQUEUED;
            state_in      = ST_IDLE;
         end
         ST_GROUP: begin
            if (!stat.group_any) begin
               ctrl.rsp_en   = 1'b1;
               ctrl.rsp_code = STATUS_KEPT;
               state_in      = ST_IDLE;
            end else begin
               ctrl.find_group = 1'b1;
               state_in        = ST_PRIO;
            end
         end
         ST_PRIO: begin
            ctrl.find_prio = 1'b1;
            state_in       = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.keep_current) begin
               ctrl.rsp_en   = 1'b1;
               ctrl.rsp_code = STATUS_KEPT;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            ctrl.pop = 1'b1;
            if (stat.head_is_tail) begin
               ctrl.rsp_en   = 1'b1;
               ctrl.rsp_code = STATUS_CHOSE;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            ctrl.advance  = 1'b1;
            ctrl.rsp_en   = 1'b1;
            ctrl.rsp_code = STATUS_CHOSE;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   // checks
   `PBRQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy_ff, busy_ff)
   `PBRQ_ASSERT_NEXT(a_rsp_frees, clock, reset, ctrl.rsp_en, !busy_ff)
   `PBRQ_ASSERT_IMPLY(a_pop_nonempty, clock, reset, ctrl.pop, stat.group_any)
   `PBRQ_ASSERT_IMPLY(a_first_not_ready, clock, reset, ctrl.enq_first, !stat.tid_ready)

endmodule

/* rtl/pbrq_datapath.sv */
// ----------------------------------------------------------------------------
// pbrq_datapath
// ready flags, two-level bitmap, queue link memories and result register
// ----------------------------------------------------------------------------
module pbrq_datapath #(
   parameter int NUM_PRIOS   = pbrq_pkg::DEF_NUM_PRIOS,
   parameter int NUM_THREADS = pbrq_pkg::DEF_NUM_THREADS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbrq_pkg::ctrl_type              ctrl,
   output pbrq_pkg::stat_type              stat,
   input  logic [pbrq_pkg::CMD_W-1:0]       req_command,
   input  logic [pbrq_pkg::THREAD_ID_W-1:0] req_thread_id,
   input  logic [pbrq_pkg::PRIO_W-1:0]      req_prio,
   input  logic [pbrq_pkg::THREAD_ID_W-1:0] req_current_id,
   input  logic                            req_current_runnable,
   input  logic [pbrq_pkg::PRIO_W-1:0]      req_current_prio,
   input  logic                            req_current_budget_left,
   output logic                            rsp_valid,
   output logic [pbrq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pbrq_pkg::THREAD_ID_W-1:0] rsp_chosen_id,
   output logic [pbrq_pkg::PRIO_W-1:0]      rsp_chosen_prio
);

   import pbrq_pkg::*;

   localparam int TW         = $clog2(NUM_THREADS);
   localparam int PW         = $clog2(NUM_PRIOS);
   localparam int NUM_GROUPS = (NUM_PRIOS + PRIOS_PER_GROUP - 1) / PRIOS_PER_GROUP;
   localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int CW         = (PW > PRIO_W) ? PW : PRIO_W;
   localparam int HW         = GW + GROUP_SHIFT;
   localparam int NUM_IDS    = 2 ** THREAD_ID_W;

   // latched transaction
   logic                   choose_ff;
   logic                   ahead_ff;
   logic [TW-1:0]          tid_ff;
   logic [PW-1:0]          p_ff;
   logic [THREAD_ID_W-1:0] cur_id_ff;
   logic                   cur_run_ff;
   logic [PRIO_W-1:0]      cur_prio_ff;
   logic                   cur_budget_ff;

   // choose search results
   logic [GW-1:0]          g_ff;
   logic [PW-1:0]          hp_ff;

   // ready flags and bitmap
   logic [NUM_THREADS-1:0]     ready_ff;
   logic [NUM_GROUPS-1:0]      group_bits_ff;
   logic [PRIOS_PER_GROUP-1:0] prio_bits_ff [NUM_GROUPS];

   // result register
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [THREAD_ID_W-1:0] rsp_id_ff;
   logic [PRIO_W-1:0]      rsp_prio_ff;

   // thread id wrap table
   logic [TW-1:0] tid_wrap [NUM_IDS];
   for (genvar i = 0; i < NUM_IDS; i++) begin : g_wrap
      assign tid_wrap[i] = TW'(i % NUM_THREADS);
   end

   // input priority saturation
   logic [PW-1:0] p_sat;
   always_comb begin
      if (32'(req_prio) >= NUM_PRIOS) p_sat = PW'(NUM_PRIOS - 1);
      else                            p_sat = PW'(req_prio);
   end

   // memory ports
   logic          head_we, tail_we, link_we;
   logic [PW-1:0] head_waddr, q_raddr;
   logic [TW-1:0] head_wdata, link_waddr, link_wdata;
   logic [TW-1:0] head_rdata, tail_rdata, link_rdata;

   always_comb begin
      head_we    = ctrl.enq_first | (ctrl.enq_link & ahead_ff) | ctrl.advance;
      head_waddr = ctrl.advance ? hp_ff : p_ff;
      head_wdata = ctrl.advance ? link_rdata : tid_ff;
      tail_we    = ctrl.enq_first | (ctrl.enq_link & !ahead_ff);
      link_we    = ctrl.enq_link;
      link_waddr = ahead_ff ? tid_ff : tail_rdata;
      link_wdata = ahead_ff ? head_rdata : tid_ff;
      q_raddr    = choose_ff ? hp_ff : p_ff;
   end

   pbrq_ram #(.WIDTH(TW), .DEPTH(NUM_PRIOS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (q_raddr),
      .rd_data (head_rdata)
   );

   pbrq_ram #(.WIDTH(TW), .DEPTH(NUM_PRIOS)) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (p_ff),
      .wr_data (tid_ff),
      .rd_addr (q_raddr),
      .rd_data (tail_rdata)
   );

   pbrq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (head_rdata),
      .rd_data (link_rdata)
   );

   // bitmap coordinates of the enqueue and of the popped priority
   logic [GW-1:0]          gp, gh;
   logic [GROUP_SHIFT-1:0] bp, bh;
   assign gp = GW'(p_ff >> GROUP_SHIFT);
   assign bp = GROUP_SHIFT'(p_ff);
   assign gh = GW'(hp_ff >> GROUP_SHIFT);
   assign bh = GROUP_SHIFT'(hp_ff);

   // highest non-empty group
   logic [GW-1:0] g_top;
   always_comb begin
      g_top = '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         if (group_bits_ff[i]) g_top = GW'(i);
      end
   end

   // highest priority inside the chosen group
   logic [HW-1:0] hp_wide;
   logic [PW-1:0] hp_sat;
   always_comb begin
      hp_wide = {g_ff, top_bit32(prio_bits_ff[g_ff])};
      if (hp_wide > HW'(NUM_PRIOS - 1)) hp_sat = PW'(NUM_PRIOS - 1);
      else                              hp_sat = PW'(hp_wide);
   end

   // bitmap word after the popped priority empties
   logic [PRIOS_PER_GROUP-1:0] word_clr;
   assign word_clr = prio_bits_ff[gh] & ~(PRIOS_PER_GROUP'(1) << bh);

   // status to the controller
   logic [CW-1:0] cur_cmp, hp_cmp;
   always_comb begin
      cur_cmp             = CW'(cur_prio_ff);
      hp_cmp              = CW'(hp_ff);
      stat.tid_ready      = ready_ff[tid_ff];
      stat.prio_nonempty  = prio_bits_ff[gp][bp];
      stat.group_any      = |group_bits_ff;
      stat.keep_current   = cur_run_ff &&
                            ((cur_cmp > hp_cmp) || ((cur_cmp == hp_cmp) && cur_budget_ff));
      stat.head_is_tail   = (head_rdata == tail_rdata);
   end

   // transaction latch and search registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         choose_ff     <= req_command[CMD_CHOOSE_BIT];
         ahead_ff      <= (req_command == CMD_ENQ_HEAD);
         tid_ff        <= tid_wrap[req_thread_id];
         p_ff          <= p_sat;
         cur_id_ff     <= req_current_id;
         cur_run_ff    <= req_current_runnable;
         cur_prio_ff   <= req_current_prio;
         cur_budget_ff <= req_current_budget_left;
      end
      if (ctrl.find_group) g_ff  <= g_top;
      if (ctrl.find_prio)  hp_ff <= hp_sat;
   end

   // ready flags and bitmap
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff      <= '0;
         group_bits_ff <= '0;
         for (int i = 0; i < NUM_GROUPS; i++) prio_bits_ff[i] <= '0;
      end else begin
         if (ctrl.enq_first || ctrl.enq_link) begin
            ready_ff[tid_ff]     <= 1'b1;
            prio_bits_ff[gp][bp] <= 1'b1;
            group_bits_ff[gp]    <= 1'b1;
         end
         if (ctrl.pop) begin
            ready_ff[head_rdata] <= 1'b0;
            if (stat.head_is_tail) begin
               prio_bits_ff[gh] <= word_clr;
               if (word_clr == '0) group_bits_ff[gh] <= 1'b0;
            end
         end
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ctrl.rsp_en;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (ctrl.rsp_en) begin
         rsp_status_ff <= ctrl.rsp_code;
         unique case (ctrl.rsp_code)
            STATUS_CHOSE: begin
               rsp_id_ff   <= THREAD_ID_W'(head_rdata);
               rsp_prio_ff <= PRIO_W'(hp_ff);
            end
            STATUS_KEPT: begin
               rsp_id_ff   <= cur_id_ff;
               rsp_prio_ff <= cur_prio_ff;
            end
            default: begin
               rsp_id_ff   <= '0;
               rsp_prio_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_id   = rsp_id_ff;
   assign rsp_chosen_prio = rsp_prio_ff;

endmodule

/* verif/tb_priority_bitmap_ready_queue.sv */
// ----------------------------------------------------------------------------
// tb_priority_bitmap_ready_queue
// self-checking bench for the per-cpu ready queue: commands are driven
// through the start/busy port and each result strobe is compared field by
// field against a behavioral scheduler kept inside the bench
// ----------------------------------------------------------------------------
module tb_priority_bitmap_ready_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import pbrq_pkg::*;

   // sizes and command codes
   localparam int N_PRIOS      = DEF_NUM_PRIOS;
   localparam int N_THREADS    = DEF_NUM_THREADS;
   localparam int N_GROUPS     = N_PRIOS / PRIOS_PER_GROUP;
   localparam logic [CMD_W-1:0] CMD_ENQ_TAIL   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CHOOSE     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CHOOSE_ALT = 2'd3;
   localparam logic [PRIO_W-1:0]      PRIO_MAX = 8'd255;
   localparam logic [THREAD_ID_W-1:0] TID_MAX  = 6'd63;

   // run control
   localparam realtime CLK_PERIOD   = 12.0;
   localparam int      RESET_CYCLES = 10;
   localparam int      RANDOM_ITEMS = 930;
   localparam int      DRAIN_CYCLES = 16;
   localparam int      CYCLE_LIMIT  = 400000;

   typedef struct packed {
      status_type               status;
      logic [THREAD_ID_W-1:0]   id;
      logic [PRIO_W-1:0]        prio;
   } sched_result_type;

   // dut ports
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [CMD_W-1:0]       req_command;
   logic [THREAD_ID_W-1:0] req_thread_id;
   logic [PRIO_W-1:0]      req_prio;
   logic [THREAD_ID_W-1:0] req_current_id;
   logic                   req_current_runnable;
   logic [PRIO_W-1:0]      req_current_prio;
   logic                   req_current_budget_left;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [THREAD_ID_W-1:0] rsp_chosen_id;
   logic [PRIO_W-1:0]      rsp_chosen_prio;

   // scheduler state mirrored by the bench
   bit                     thread_ready [N_THREADS];
   logic [THREAD_ID_W-1:0] thread_link  [N_THREADS];
   logic [THREAD_ID_W-1:0] fifo_head    [N_PRIOS];
   logic [THREAD_ID_W-1:0] fifo_tail    [N_PRIOS];
   logic [N_GROUPS-1:0]    group_map;
   logic [PRIOS_PER_GROUP-1:0] prio_map [N_GROUPS];
   int                     ready_count;

   sched_result_type       pending_results[$];
   int unsigned            error_count = 0;
   int unsigned            cycle_count = 0;
   bit                     burst_mode  = 1'b0;

   priority_bitmap_ready_queue u_top (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_command             (req_command),
      .req_thread_id           (req_thread_id),
      .req_prio                (req_prio),
      .req_current_id          (req_current_id),
      .req_current_runnable    (req_current_runnable),
      .req_current_prio        (req_current_prio),
      .req_current_budget_left (req_current_budget_left),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_chosen_id           (rsp_chosen_id),
      .rsp_chosen_prio         (rsp_chosen_prio)
   );

   // clock
   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // highest non-empty priority, or -1 when nothing is queued
   function automatic int top_queued_prio();
      int grp;
      int bitpos;
      grp = -1;
      bitpos = -1;
      for (int i = 0; i < N_GROUPS; i++) if (group_map[i]) grp = i;
      if (grp < 0) return -1;
      for (int i = 0; i < PRIOS_PER_GROUP; i++) if (prio_map[grp][i]) bitpos = i;
      return grp * PRIOS_PER_GROUP + bitpos;
   endfunction

   // apply one command to the mirrored queue and return its result
   function automatic sched_result_type schedule_step(
      input logic [CMD_W-1:0]       cmd,
      input logic [THREAD_ID_W-1:0] tid,
      input logic [PRIO_W-1:0]      prio,
      input logic [THREAD_ID_W-1:0] cur_id,
      input logic                   cur_run,
      input logic [PRIO_W-1:0]      cur_prio,
      input logic                   cur_budget
   );
      sched_result_type       res;
      int                     grp;
      int                     hp;
      logic [THREAD_ID_W-1:0] popped;
      res.status = STATUS_ENQUEUED;
      res.id     = '0;
      res.prio   = '0;
      // enqueue at tail or head
      if (!cmd[CMD_CHOOSE_BIT]) begin
         if (thread_ready[tid]) begin
            res.status = STATUS_REJECTED;
            return res;
         end
         thread_ready[tid] = 1'b1;
         ready_count++;
         grp = int'(prio >> GROUP_SHIFT);
         if (!prio_map[grp][prio[GROUP_SHIFT-1:0]]) begin
            fifo_head[prio] = tid;
            fifo_tail[prio] = tid;
         end else if (cmd == CMD_ENQ_HEAD) begin
            thread_link[tid] = fifo_head[prio];
            fifo_head[prio]  = tid;
         end else begin
            thread_link[fifo_tail[prio]] = tid;
            fifo_tail[prio] = tid;
         end
         group_map[grp] = 1'b1;
         prio_map[grp][prio[GROUP_SHIFT-1:0]] = 1'b1;
         return res;
      end
      // choose: keep current or pop the highest fifo
      hp = top_queued_prio();
      if (hp < 0 || (cur_run && (int'(cur_prio) > hp ||
                                 (int'(cur_prio) == hp && cur_budget)))) begin
         res.status = STATUS_KEPT;
         res.id     = cur_id;
         res.prio   = cur_prio;
         return res;
      end
      popped = fifo_head[hp];
      thread_ready[popped] = 1'b0;
      ready_count--;
      grp = hp / PRIOS_PER_GROUP;
      if (popped == fifo_tail[hp]) begin
         prio_map[grp][hp % PRIOS_PER_GROUP] = 1'b0;
         if (prio_map[grp] == '0) group_map[grp] = 1'b0;
      end else begin
         fifo_head[hp] = thread_link[popped];
      end
      res.status = STATUS_CHOSE;
      res.id     = popped;
      res.prio   = PRIO_W'(hp);
      return res;
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // drive one command transaction and record its expected result on accept
   task automatic issue_command(
      input logic [CMD_W-1:0]       cmd,
      input logic [THREAD_ID_W-1:0] tid,
      input logic [PRIO_W-1:0]      prio,
      input logic [THREAD_ID_W-1:0] cur_id,
      input logic                   cur_run,
      input logic [PRIO_W-1:0]      cur_prio,
      input logic                   cur_budget,
      input int                     gap
   );
      repeat (gap) begin
         @(negedge clock);
         start                   <= 1'b0;
         req_command             <= CMD_W'($urandom);
         req_thread_id           <= THREAD_ID_W'($urandom);
         req_prio                <= PRIO_W'($urandom);
         req_current_id          <= THREAD_ID_W'($urandom);
         req_current_runnable    <= 1'($urandom);
         req_current_prio        <= PRIO_W'($urandom);
         req_current_budget_left <= 1'($urandom);
      end
      @(negedge clock);
      start                   <= 1'b1;
      req_command             <= cmd;
      req_thread_id           <= tid;
      req_prio                <= prio;
      req_current_id          <= cur_id;
      req_current_runnable    <= cur_run;
      req_current_prio        <= cur_prio;
      req_current_budget_left <= cur_budget;
      do @(posedge clock); while (busy);
      pending_results.push_back(schedule_step(cmd, tid, prio, cur_id, cur_run,
                                              cur_prio, cur_budget));
   endtask

   // one field compare with report
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin : check_results
      sched_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display({"%0t: result with none expected, expected none, ",
                      "actual status %0d id %0d prio %0d"},
                     $time, rsp_status, rsp_chosen_id, rsp_chosen_prio);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", int'(want.status), int'(rsp_status));
            check_field("chosen_id", int'(want.id), int'(rsp_chosen_id));
            check_field("chosen_prio", int'(want.prio), int'(rsp_chosen_prio));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // choose on an empty bitmap keeps current regardless of runnable
   task automatic test_empty_bitmap();
      issue_command(CMD_CHOOSE, '0, '0, TID_MAX, 1'b0, PRIO_MAX, 1'b0, 0);
      issue_command(CMD_CHOOSE_ALT, TID_MAX, PRIO_MAX, '0, 1'b1, '0, 1'b1, 2);
   endtask

   // field extremes, head and tail order, group boundary, rejected duplicate
   task automatic test_enqueue_order();
      issue_command(CMD_ENQ_TAIL, '0, '0, '0, 1'b0, '0, 1'b0, 0);
      issue_command(CMD_ENQ_TAIL, TID_MAX, PRIO_MAX, TID_MAX, 1'b1, PRIO_MAX, 1'b1, 0);
      issue_command(CMD_ENQ_HEAD, '0, 8'd7, '0, 1'b0, '0, 1'b0, 1);
      issue_command(CMD_ENQ_TAIL, 6'd5, 8'd200, '0, 1'b0, '0, 1'b0, 0);
      issue_command(CMD_ENQ_TAIL, 6'd6, 8'd200, '0, 1'b0, '0, 1'b0, 0);
      issue_command(CMD_ENQ_HEAD, 6'd7, 8'd200, '0, 1'b0, '0, 1'b0, 3);
      issue_command(CMD_ENQ_HEAD, 6'd9, 8'd31, '0, 1'b0, '0, 1'b0, 0);
      issue_command(CMD_ENQ_HEAD, 6'd10, 8'd32, '0, 1'b0, '0, 1'b0, 0);
      // drain everything with a suspended current thread
      repeat (8) issue_command(CMD_CHOOSE, '0, '0, 6'd33, 1'b0, PRIO_MAX, 1'b1, 0);
   endtask

   // keep rules: higher priority, equal with budget, equal without, not runnable
   task automatic test_keep_current();
      issue_command(CMD_ENQ_TAIL, 6'd20, 8'd100, '0, 1'b0, '0, 1'b0, 0);
      issue_command(CMD_ENQ_TAIL, 6'd21, 8'd100, '0, 1'b0, '0, 1'b0, 0);
      issue_command(CMD_CHOOSE, '0, '0, 6'd40, 1'b1, 8'd101, 1'b0, 0);
      issue_command(CMD_CHOOSE, '0, '0, 6'd41, 1'b1, 8'd100, 1'b1, 0);
      issue_command(CMD_CHOOSE, '0, '0, 6'd42, 1'b1, 8'd100, 1'b0, 0);
      issue_command(CMD_CHOOSE_ALT, '0, '0, 6'd43, 1'b0, PRIO_MAX, 1'b1, 0);
   endtask

   // random traffic shaped to build deep fifos across several priorities
   task automatic test_random_traffic();
      logic [PRIO_W-1:0]      prio_pool [4];
      logic [CMD_W-1:0]       cmd;
      logic [THREAD_ID_W-1:0] tid;
      logic [PRIO_W-1:0]      prio;
      logic [PRIO_W-1:0]      cur_prio;
      int                     enq_pct;
      int                     hp;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // phase changes: pacing and the set of busy priorities
         if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if (n % 100 == 0) foreach (prio_pool[i]) prio_pool[i] = PRIO_W'($urandom);
         enq_pct = (ready_count < 8) ? 75 : ((ready_count > 48) ? 25 : 55);
         if ($urandom_range(0, 99) < enq_pct) begin
            cmd = $urandom_range(0, 1) ? CMD_ENQ_HEAD : CMD_ENQ_TAIL;
            tid = THREAD_ID_W'($urandom);
            if (ready_count < N_THREADS && $urandom_range(0, 9) != 0)
               while (thread_ready[tid]) tid = THREAD_ID_W'($urandom);
            prio = ($urandom_range(0, 9) < 6) ? prio_pool[$urandom_range(0, 3)]
                                               : PRIO_W'($urandom);
            issue_command(cmd, tid, prio, THREAD_ID_W'($urandom), 1'($urandom),
                          PRIO_W'($urandom), 1'($urandom), pick_gap());
         end else begin
            cmd = ($urandom_range(0, 9) == 0) ? CMD_CHOOSE_ALT : CMD_CHOOSE;
            hp = top_queued_prio();
            cur_prio = PRIO_W'($urandom);
            // aim the current priority at the top of the queue
            if (hp >= 0 && $urandom_range(0, 9) < 4)
               cur_prio = PRIO_W'(hp + $urandom_range(0, 2) - 1);
            issue_command(cmd, THREAD_ID_W'($urandom), PRIO_W'($urandom),
                          THREAD_ID_W'($urandom), ($urandom_range(0, 9) < 7),
                          cur_prio, 1'($urandom), pick_gap());
         end
      end
   endtask

   // main sequence
   initial begin
      reset                   = 1'b1;
      start                   = 1'b0;
      req_command             = '0;
      req_thread_id           = '0;
      req_prio                = '0;
      req_current_id          = '0;
      req_current_runnable    = 1'b0;
      req_current_prio        = '0;
      req_current_budget_left = 1'b0;
      ready_count             = 0;
      group_map               = '0;
      foreach (thread_ready[i]) begin
         thread_ready[i] = 1'b0;
         thread_link[i]  = '0;
      end
      foreach (fifo_head[i]) begin
         fifo_head[i] = '0;
         fifo_tail[i] = '0;
      end
      foreach (prio_map[i]) prio_map[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_bitmap();
      test_enqueue_order();
      test_keep_current();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
